@@ design/akr_pkg.sv @@
// Shared types and constants for the accelerating key repeat engine.
// No dependencies; imported by every other design file.
package akr_pkg;

    // Field and register widths
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 4;

    // Action codes
    localparam logic [1:0] ACT_PRESS   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    // Event kinds
    localparam logic [1:0] EVT_DOWN   = 2'd0;
    localparam logic [1:0] EVT_REPEAT = 2'd1;
    localparam logic [1:0] EVT_UP     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_INTV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE      = 3'd4;

    // Configuration reset values
    localparam logic [CFG_W-1:0] INIT_DELAY_RST = 16'd320;
    localparam logic [CFG_W-1:0] START_INTV_RST = 16'd120;
    localparam logic [CFG_W-1:0] MIN_INTV_RST   = 16'd45;
    localparam logic [CFG_W-1:0] RAMP_RST       = 16'd1000;
    localparam logic [CFG_W-1:0] GRACE_RST      = 16'd120;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_REL,
        S_REL_UP,
        S_T_EVAL,
        S_T_MUL,
        S_T_DIVLD,
        S_T_DIV,
        S_T_RWR,
        S_T_FLUSH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic do_press;
        logic rel_down;
        logic rel_up;
        logic fire_defer;
        logic push_repeat;
        logic ramp_zero_wr;
        logic mul_load;
        logic mul_go;
        logic div_start;
        logic rpt_wr;
        logic addr_inc;
        logic flush;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] act;
        logic       slot_ok;
        logic       held;
        logic       pending;
        logic       repeatable;
        logic       grace_due;
        logic       rpt_due;
        logic       ramp_zero;
        logic       last_slot;
        logic       div_done;
    } stat_t;

endpackage

@@ design/akr_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on akr_pkg. Caller guarantees the quotient fits in 16 bits.
module akr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [2*akr_pkg::CFG_W-1:0] dividend,
    input  logic [akr_pkg::CFG_W-1:0]   divisor,
    output logic                       done,
    output logic [akr_pkg::CFG_W-1:0]   quotient
);
    import akr_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [CFG_W-1:0]     low_reg;
    logic [CFG_W:0]       trial;
    logic                 ge;
    logic [CFG_W-1:0]     rem_next;
    logic [CFG_W-1:0]     low_next;

    // One trial subtraction per step
    always_comb
    begin
        trial    = {rem_reg, low_reg[CFG_W-1]} - {1'b0, divisor};
        ge       = ~trial[CFG_W];
        rem_next = ge ? trial[CFG_W-1:0] : {rem_reg[CFG_W-2:0], low_reg[CFG_W-1]};
        low_next = {low_reg[CFG_W-2:0], ge};
    end

    assign done     = busy_reg && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign quotient = low_reg;

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (done)
                busy_reg <= 1'b0;
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[2*CFG_W-1:CFG_W];
            low_reg <= dividend[CFG_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

@@ design/akr_dp.sv @@
// Datapath: configuration, slot flags and tables, ramp arithmetic, event output.
// Depends on akr_pkg and akr_div; driven by akr_ctrl through cmd_t.
module akr_dp #(
    parameter int SLOT_COUNT = 32,
    parameter int KEY_BITS   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  akr_pkg::cmd_t                  cmd,
    output akr_pkg::stat_t                 st,
    input  logic [1:0]                     action,
    input  logic [4:0]                     slot,
    input  logic [KEY_BITS-1:0]            key_code,
    input  logic                           can_repeat,
    input  logic                           defer_press,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [akr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [akr_pkg::CFG_W-1:0]      cfg_data,
    output logic                           out_valid,
    output logic [1:0]                     event_kind,
    output logic [KEY_BITS-1:0]            out_key,
    output logic [4:0]                     out_slot,
    output logic                           last
);
    import akr_pkg::*;

    localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Configuration and time
    logic [TIME_W-1:0] tick_reg;
    logic [CFG_W-1:0]  init_reg;
    logic [CFG_W-1:0]  start_reg;
    logic [CFG_W-1:0]  min_reg;
    logic [CFG_W-1:0]  ramp_reg;
    logic [CFG_W-1:0]  grace_reg;

    // Slot flags
    logic [SLOT_COUNT-1:0] held_reg;
    logic [SLOT_COUNT-1:0] pend_reg;
    logic [SLOT_COUNT-1:0] rep_reg;

    // Latched transaction
    logic [1:0]          act_reg;
    logic [4:0]          slot_in_reg;
    logic [KEY_BITS-1:0] key_in_reg;
    logic                rep_in_reg;
    logic                defer_in_reg;

    logic [SIDX_W-1:0] addr_reg;
    logic [SIDX_W-1:0] addr_next;

    // Slot tables
    logic [KEY_BITS-1:0] key_mem   [SLOT_COUNT];
    logic [TIME_W-1:0]   ptime_mem [SLOT_COUNT];
    logic [TIME_W-1:0]   nrep_mem  [SLOT_COUNT];
    logic [KEY_BITS-1:0] key_rd_reg;
    logic [TIME_W-1:0]   ptime_rd_reg;
    logic [TIME_W-1:0]   nrep_rd_reg;

    // Ramp arithmetic
    logic [TIME_W-1:0]   held32;
    logic [TIME_W-1:0]   since32;
    logic [CFG_W-1:0]    h_next;
    logic [CFG_W-1:0]    diff_next;
    logic                up_next;
    logic [CFG_W-1:0]    h_reg;
    logic [CFG_W-1:0]    diff_reg;
    logic                up_reg;
    logic [2*CFG_W-1:0]  prod_reg;
    logic [2*CFG_W-1:0]  div_dividend;
    logic [CFG_W-1:0]    div_q;
    logic                div_done;
    logic [CFG_W-1:0]    interval;

    // Table write data
    logic [CFG_W-1:0]  nrep_add;
    logic              nrep_zero;
    logic [TIME_W-1:0] nrep_wd;
    logic              ptime_we;
    logic              nrep_we;

    // Held-back event and output registers
    logic                pend_valid_reg;
    logic [1:0]          pend_kind_reg;
    logic [KEY_BITS-1:0] pend_key_reg;
    logic [SIDX_W-1:0]   pend_slot_reg;
    logic                pend_valid_next;
    logic [1:0]          pend_kind_next;
    logic [KEY_BITS-1:0] pend_key_next;
    logic [SIDX_W-1:0]   pend_slot_next;
    logic                out_valid_reg;
    logic [1:0]          out_kind_reg;
    logic [KEY_BITS-1:0] out_key_reg;
    logic [SIDX_W-1:0]   out_slot_reg;
    logic                out_last_reg;
    logic                out_valid_next;
    logic [1:0]          out_kind_next;
    logic [KEY_BITS-1:0] out_key_next;
    logic [SIDX_W-1:0]   out_slot_next;
    logic                out_last_next;
    logic                push;

    // Slot address
    always_comb
    begin
        if (cmd.accept)
            addr_next = (action == ACT_TICK) ? '0 : SIDX_W'(slot);
        else if (cmd.addr_inc)
            addr_next = addr_reg + 1'b1;
        else
            addr_next = addr_reg;
    end

    // Time differences and ramp operands
    always_comb
    begin
        held32    = tick_reg - ptime_rd_reg;
        since32   = tick_reg - nrep_rd_reg;
        h_next    = (held32 < {16'd0, ramp_reg}) ? held32[CFG_W-1:0] : ramp_reg;
        up_next   = (min_reg >= start_reg);
        diff_next = up_next ? (min_reg - start_reg) : (start_reg - min_reg);
        // rounding up when the interval grows
        div_dividend = up_reg ? (prod_reg + {16'd0, ramp_reg} - 32'd1) : prod_reg;
        interval     = up_reg ? (start_reg + div_q) : (start_reg - div_q);
    end

    // Next-repeat write data
    always_comb
    begin
        if (cmd.rpt_wr)
            nrep_add = interval;
        else if (cmd.ramp_zero_wr)
            nrep_add = min_reg;
        else
            nrep_add = init_reg;
        nrep_zero = (cmd.do_press && !(rep_in_reg && !defer_in_reg)) ||
                    (cmd.fire_defer && !rep_reg[addr_reg]);
        nrep_wd   = nrep_zero ? '0 : (tick_reg + {16'd0, nrep_add});
        ptime_we  = cmd.do_press || cmd.fire_defer;
        nrep_we   = cmd.do_press || cmd.fire_defer || cmd.ramp_zero_wr || cmd.rpt_wr;
    end

    // Status to controller
    always_comb
    begin
        st.act        = act_reg;
        st.slot_ok    = (32'(slot_in_reg) < 32'(SLOT_COUNT));
        st.held       = held_reg[addr_reg];
        st.pending    = pend_reg[addr_reg];
        st.repeatable = rep_reg[addr_reg];
        st.grace_due  = (held32 >= {16'd0, grace_reg});
        st.rpt_due    = ~since32[TIME_W-1];
        st.ramp_zero  = (ramp_reg == '0);
        st.last_slot  = (addr_reg == SIDX_W'(SLOT_COUNT - 1));
        st.div_done   = div_done;
    end

    // Event emission; tick events are held back one step to mark the last
    always_comb
    begin
        push            = cmd.fire_defer || cmd.push_repeat;
        out_valid_next  = 1'b0;
        out_kind_next   = out_kind_reg;
        out_key_next    = out_key_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_key_next   = pend_key_reg;
        pend_slot_next  = pend_slot_reg;
        if (cmd.do_press && !defer_in_reg)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = EVT_DOWN;
            out_key_next   = key_in_reg;
            out_slot_next  = addr_reg;
            out_last_next  = 1'b1;
        end
        if (cmd.rel_down || cmd.rel_up)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = cmd.rel_up ? EVT_UP : EVT_DOWN;
            out_key_next   = key_rd_reg;
            out_slot_next  = addr_reg;
            out_last_next  = cmd.rel_up;
        end
        if ((push || cmd.flush) && pend_valid_reg)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = pend_kind_reg;
            out_key_next   = pend_key_reg;
            out_slot_next  = pend_slot_reg;
            out_last_next  = cmd.flush;
        end
        if (push)
        begin
            pend_valid_next = 1'b1;
            pend_kind_next  = cmd.fire_defer ? EVT_DOWN : EVT_REPEAT;
            pend_key_next   = key_rd_reg;
            pend_slot_next  = addr_reg;
        end
        if (cmd.flush)
            pend_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            init_reg       <= INIT_DELAY_RST;
            start_reg      <= START_INTV_RST;
            min_reg        <= MIN_INTV_RST;
            ramp_reg       <= RAMP_RST;
            grace_reg      <= GRACE_RST;
            held_reg       <= '0;
            pend_reg       <= '0;
            rep_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_INIT_DELAY: init_reg  <= cfg_data;
                    CFG_START_INTV: start_reg <= cfg_data;
                    CFG_MIN_INTV:   min_reg   <= cfg_data;
                    CFG_RAMP:       ramp_reg  <= cfg_data;
                    CFG_GRACE:      grace_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.accept && (action == ACT_TICK))
                tick_reg <= tick_reg + 1'b1;
            if (cmd.do_press)
            begin
                held_reg[addr_reg] <= 1'b1;
                pend_reg[addr_reg] <= defer_in_reg;
                rep_reg[addr_reg]  <= rep_in_reg;
            end
            if (cmd.fire_defer)
                pend_reg[addr_reg] <= 1'b0;
            if (cmd.rel_up)
            begin
                held_reg[addr_reg] <= 1'b0;
                pend_reg[addr_reg] <= 1'b0;
                rep_reg[addr_reg]  <= 1'b0;
            end
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (cmd.accept)
        begin
            act_reg      <= action;
            slot_in_reg  <= slot;
            key_in_reg   <= key_code;
            rep_in_reg   <= can_repeat;
            defer_in_reg <= defer_press;
        end
        if (cmd.mul_load)
        begin
            h_reg    <= h_next;
            diff_reg <= diff_next;
            up_reg   <= up_next;
        end
        if (cmd.mul_go)
            prod_reg <= {16'd0, diff_reg} * {16'd0, h_reg};
        pend_kind_reg <= pend_kind_next;
        pend_key_reg  <= pend_key_next;
        pend_slot_reg <= pend_slot_next;
        out_kind_reg  <= out_kind_next;
        out_key_reg   <= out_key_next;
        out_slot_reg  <= out_slot_next;
        out_last_reg  <= out_last_next;
    end

    // Slot tables, read one step ahead at the next address
    always_ff @(posedge clk)
    begin
        if (cmd.do_press)
            key_mem[addr_reg] <= key_in_reg;
        if (ptime_we)
            ptime_mem[addr_reg] <= tick_reg;
        if (nrep_we)
            nrep_mem[addr_reg] <= nrep_wd;
        key_rd_reg   <= key_mem[addr_next];
        ptime_rd_reg <= ptime_mem[addr_next];
        nrep_rd_reg  <= nrep_mem[addr_next];
    end

    akr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (ramp_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign out_key    = out_key_reg;
    assign out_slot   = 5'(out_slot_reg);
    assign last       = out_last_reg;

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |=> !out_valid_reg)
        else $error("event strobe right after the last event of a transaction");

    a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !pend_valid_reg)
        else $error("held-back event left over at a new transaction");

endmodule

@@ design/akr_ctrl.sv @@
// Controller FSM: sequences press, release and the per-tick slot walk.
// Depends on akr_pkg; talks to akr_dp only through cmd_t and stat_t.
module akr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  akr_pkg::stat_t  st,
    output akr_pkg::cmd_t   cmd,
    output logic            busy
);
    import akr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   adv;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        adv        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.act)
                    ACT_PRESS:
                    begin
                        cmd.do_press = st.slot_ok && !st.held;
                        state_next   = S_IDLE;
                    end
                    ACT_RELEASE:
                        state_next = (st.slot_ok && st.held) ? S_REL : S_IDLE;
                    ACT_TICK:
                        state_next = S_T_EVAL;
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_REL:
            begin
                if (st.pending)
                begin
                    cmd.rel_down = 1'b1;
                    state_next   = S_REL_UP;
                end
                else
                begin
                    cmd.rel_up = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REL_UP:
            begin
                cmd.rel_up = 1'b1;
                state_next = S_IDLE;
            end
            S_T_EVAL:
            begin
                adv = 1'b1;
                if (st.held && st.pending)
                    cmd.fire_defer = st.grace_due;
                else if (st.held && st.repeatable && st.rpt_due)
                begin
                    cmd.push_repeat = 1'b1;
                    if (st.ramp_zero)
                        cmd.ramp_zero_wr = 1'b1;
                    else
                    begin
                        cmd.mul_load = 1'b1;
                        adv          = 1'b0;
                        state_next   = S_T_MUL;
                    end
                end
            end
            S_T_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_T_DIVLD;
            end
            S_T_DIVLD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_T_DIV;
            end
            S_T_DIV:
            begin
                if (st.div_done)
                    state_next = S_T_RWR;
            end
            S_T_RWR:
            begin
                cmd.rpt_wr = 1'b1;
                adv        = 1'b1;
                state_next = S_T_EVAL;
            end
            S_T_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        // move to the next slot or finish the walk
        if (adv)
        begin
            if (st.last_slot)
                state_next = S_T_FLUSH;
            else
                cmd.addr_inc = 1'b1;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_one_event_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.do_press, cmd.rel_down, cmd.rel_up, cmd.fire_defer,
                  cmd.push_repeat, cmd.flush}))
        else $error("more than one event command in a cycle");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_T_DIVLD) |=> (state_reg == S_T_DIV))
        else $error("divider launch not followed by wait state");

endmodule

@@ design/accelerating_key_repeat_engine.sv @@
// Typematic key auto-repeat with a linear ramp of the repeat interval.
// Press: key-down strobe, unless deferred, is registered from the dispatch state after accept.
// Release: a tap gives key-down then key-up on consecutive cycles.
// Tick: a walk over every slot, one slot per cycle except while a ramped repeat waits on
// the 16-step shared divider. Results are strobed.
// Reset (rst_n low, async): all slots idle, tick count zero, registers at defaults.
module accelerating_key_repeat_engine #(
    parameter int SLOT_COUNT = 32,
    parameter int KEY_BITS   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic [4:0]                    slot,
    input  logic [KEY_BITS-1:0]           key_code,
    input  logic                          can_repeat,
    input  logic                          defer_press,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [akr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [akr_pkg::CFG_W-1:0]     cfg_data,
    output logic                          out_valid,
    output logic [1:0]                    event_kind,
    output logic [KEY_BITS-1:0]           out_key,
    output logic [4:0]                    out_slot,
    output logic                          last
);
    import akr_pkg::*;

    cmd_t  cmd;
    stat_t st;

    akr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    akr_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .action      (action),
        .slot        (slot),
        .key_code    (key_code),
        .can_repeat  (can_repeat),
        .defer_press (defer_press),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .event_kind  (event_kind),
        .out_key     (out_key),
        .out_slot    (out_slot),
        .last        (last)
    );

endmodule
